// ----- rtl/core/hpq_pkg.sv -----
// Shared types and codes for the heap priority queue.
// No dependencies; imported by hpq_ctrl and max_priority_queue_heap.
package hpq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOTAL_W = 8;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [STAT_W-1:0]        status;
    logic [TOTAL_W-1:0]       entry_total;
  } res_t;

endpackage

// ----- rtl/core/hpq_store.sv -----
// Heap storage: one write port, one read port with registered read data.
// No dependencies; instantiated by max_priority_queue_heap.
module hpq_store #(
  parameter int unsigned DEPTH = 129,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/hpq_ctrl.sv -----
// Heap sequencer: sift-up and sift-down over the storage with one shared
// signed comparator. Depends on hpq_pkg.
module hpq_ctrl #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned AW       = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [hpq_pkg::MODE_W-1:0]        mode,
  input  logic signed [hpq_pkg::DATA_W-1:0] value,
  output logic                              idle,
  output logic                              res_valid,
  output hpq_pkg::res_t                     res,
  input  logic                              res_take,
  output logic                              we,
  output logic [AW-1:0]                     waddr,
  output logic [hpq_pkg::DATA_W-1:0]        wdata,
  output logic [AW-1:0]                     raddr,
  input  logic [hpq_pkg::DATA_W-1:0]        rdata
);
  import hpq_pkg::*;

  localparam int unsigned KW = AW + 1;
  localparam logic [AW-1:0] FULL_CNT = AW'(CAPACITY);
  localparam logic [AW-1:0] ROOT     = AW'(1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP      = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_PEEK    = 4'd3;
  localparam logic [3:0] S_RM_TOP  = 4'd4;
  localparam logic [3:0] S_RM_LAST = 4'd5;
  localparam logic [3:0] S_DN      = 4'd6;
  localparam logic [3:0] S_DN_K0   = 4'd7;
  localparam logic [3:0] S_DN_K1   = 4'd8;
  localparam logic [3:0] S_DN_CMP  = 4'd9;
  localparam logic [3:0] S_RES     = 4'd10;

  logic [3:0]        state;
  logic [AW-1:0]     cnt;
  logic [AW-1:0]     idx;
  logic [KW-1:0]     kid;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] best;
  logic [AW-1:0]     best_idx;
  logic [DATA_W-1:0] top;

  logic [DATA_W-1:0] cmp_a;
  logic [DATA_W-1:0] cmp_b;
  logic              gt;
  logic              kid_over;
  logic              kid_lt;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_RES);
  assign kid_over  = kid > {1'b0, cnt};
  assign kid_lt    = kid < {1'b0, cnt};

  // Shared comparator: operands follow the step in progress
  always_comb begin
    cmp_a = val;
    cmp_b = rdata;
    case (state)
      S_DN_K1: begin
        cmp_a = rdata;
        cmp_b = best;
      end
      S_DN_CMP: begin
        cmp_a = best;
        cmp_b = val;
      end
      default: ;
    endcase
  end

  assign gt = $signed(cmp_a) > $signed(cmp_b);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = val;
    raddr = ROOT;
    case (state)
      S_UP: begin
        if (idx == ROOT) begin
          we = 1'b1;
        end else begin
          raddr = idx >> 1;
        end
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = gt ? rdata : val;
      end
      S_RM_TOP: raddr = cnt;
      S_DN: begin
        if (kid_over) begin
          we = 1'b1;
        end else begin
          raddr = kid[AW-1:0];
        end
      end
      S_DN_K0: raddr = kid[AW-1:0] + AW'(1);
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = gt ? best : val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (mode == MODE_INSERT) begin
              if (cnt == FULL_CNT) begin
                res   <= '{result_value: '0, status: ST_FULL, entry_total: TOTAL_W'(cnt)};
                state <= S_RES;
              end else begin
                cnt   <= cnt + AW'(1);
                idx   <= cnt + AW'(1);
                val   <= value;
                state <= S_UP;
              end
            end else if (cnt == '0) begin
              res   <= '{result_value: '0, status: ST_EMPTY, entry_total: '0};
              state <= S_RES;
            end else if (mode == MODE_REMOVE) begin
              state <= S_RM_TOP;
            end else begin
              state <= S_PEEK;
            end
          end
        end
        S_PEEK: begin
          res   <= '{result_value: rdata, status: ST_DONE, entry_total: TOTAL_W'(cnt)};
          state <= S_RES;
        end
        S_UP: begin
          if (idx == ROOT) begin
            res   <= '{result_value: '0, status: ST_DONE, entry_total: TOTAL_W'(cnt)};
            state <= S_RES;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (gt) begin
            // parent moved down; climb one level
            idx   <= idx >> 1;
            state <= S_UP;
          end else begin
            res   <= '{result_value: '0, status: ST_DONE, entry_total: TOTAL_W'(cnt)};
            state <= S_RES;
          end
        end
        S_RM_TOP: begin
          top   <= rdata;
          cnt   <= cnt - AW'(1);
          state <= S_RM_LAST;
        end
        S_RM_LAST: begin
          val   <= rdata;
          idx   <= ROOT;
          kid   <= KW'(2);
          state <= S_DN;
        end
        S_DN: begin
          if (kid_over) begin
            res   <= '{result_value: top, status: ST_DONE, entry_total: TOTAL_W'(cnt)};
            state <= S_RES;
          end else begin
            state <= S_DN_K0;
          end
        end
        S_DN_K0: begin
          best     <= rdata;
          best_idx <= kid[AW-1:0];
          state    <= kid_lt ? S_DN_K1 : S_DN_CMP;
        end
        S_DN_K1: begin
          // right child wins only when strictly larger
          if (gt) begin
            best     <= rdata;
            best_idx <= kid[AW-1:0] + AW'(1);
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (gt) begin
            idx   <= best_idx;
            kid   <= {best_idx, 1'b0};
            state <= S_DN;
          end else begin
            res   <= '{result_value: top, status: ST_DONE, entry_total: TOTAL_W'(cnt)};
            state <= S_RES;
          end
        end
        S_RES: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT)
    else $error("entry count above capacity");

  // removing the last entry rewrites the root slot after the count reaches zero
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr != '0) && ((waddr <= cnt) || (waddr == ROOT)))
    else $error("write outside live heap slots");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    idle && start && (mode == MODE_INSERT) && (cnt == FULL_CNT)
      |=> res_valid && (res.status == ST_FULL) && (cnt == FULL_CNT))
    else $error("insert into full queue not refused");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !idle && !$past(rst) |-> (cnt == $past(cnt)) || (cnt == $past(cnt) - AW'(1))
      || (cnt == $past(cnt) + AW'(1)))
    else $error("entry count moved by more than one");

endmodule

// ----- rtl/core/max_priority_queue_heap.sv -----
// Max priority queue of signed 32-bit values on a binary heap.
// Uses hpq_pkg, hpq_store and hpq_ctrl.
//
// Input channel: in_valid/in_stall with mode and value. mode 0 inserts value,
// 1 removes the maximum, 2 (and 3) peeks at it. Output channel:
// out_valid/out_stall with result_value, status (0 done, 1 empty, 2 full) and
// entry_total, the entry count after the item. Every item gives one beat.
// The block works on one item at a time; in_stall stays high from the accept
// until the result has left the sequencer for the output register.
// An insert level is one read, compare and write; a remove level reads the
// children and compares up to twice, all paced by the registered storage read.
// Reset empties the queue at once; stored words are not cleared.
// When out_stall holds a beat, the next item may still be accepted and run;
// its result waits in the sequencer until the output register frees up.
module max_priority_queue_heap #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hpq_pkg::MODE_W-1:0]        mode,
  input  logic signed [hpq_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hpq_pkg::DATA_W-1:0] result_value,
  output logic [hpq_pkg::STAT_W-1:0]        status,
  output logic [hpq_pkg::TOTAL_W-1:0]       entry_total
);
  import hpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY + 1);

  logic              start;
  logic              idle;
  logic              res_valid;
  res_t              res;
  logic              res_take;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  assign in_stall = !idle;
  assign start    = in_valid && idle;
  assign res_take = res_valid && (!out_valid || !out_stall);

  hpq_store #(
    .DEPTH(CAPACITY + 1),
    .AW   (AW),
    .DW   (DATA_W)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  hpq_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (mode),
    .value    (value),
    .idle     (idle),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  // Output register: load a finished result, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result_value <= res.result_value;
      status       <= res.status;
      entry_total  <= res.entry_total;
    end
  end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for max_priority_queue_heap: directed table, then random phases.
// Depends on hpq_pkg and the max_priority_queue_heap RTL; holds its own heap predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 128;
  localparam int unsigned RAND_ITEMS   = 1225;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned DIR_ROWS     = 25;
  localparam logic [MODE_W-1:0] MODE_ALT_PEEK = 2'd3;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  typedef struct packed {
    logic [MODE_W-1:0]        op;
    logic signed [DATA_W-1:0] arg;
    logic                     typed;
    res_t                     want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [MODE_W-1:0]        mode = MODE_INSERT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [STAT_W-1:0]        status;
  logic [TOTAL_W-1:0]       entry_total;

  // Predictor state: one-based heap and its entry count.
  logic signed [DATA_W-1:0] heap_mem [1:QUEUE_DEPTH];
  int unsigned              heap_cnt = 0;
  res_t                     pending_results [$];
  int unsigned              err_cnt = 0;
  int unsigned              idle_cycles = 0;
  bit                       in_gaps_on = 1'b1;
  bit                       out_stalls_on = 1'b1;

  // Typed rows hold results that follow directly from the queue contents.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{MODE_PEEK,     32'sd0,            1'b1, '{32'sd0,            ST_EMPTY, 8'd0}},
    '{MODE_REMOVE,   32'sd0,            1'b1, '{32'sd0,            ST_EMPTY, 8'd0}},
    '{MODE_ALT_PEEK, -32'sd1,           1'b1, '{32'sd0,            ST_EMPTY, 8'd0}},
    '{MODE_INSERT,   32'sh7FFF_FFFF,    1'b1, '{32'sd0,            ST_DONE,  8'd1}},
    '{MODE_PEEK,     32'sh5555_5555,    1'b1, '{32'sh7FFF_FFFF,    ST_DONE,  8'd1}},
    '{MODE_INSERT,   32'sh8000_0000,    1'b1, '{32'sd0,            ST_DONE,  8'd2}},
    '{MODE_INSERT,   -32'sd1,           1'b1, '{32'sd0,            ST_DONE,  8'd3}},
    '{MODE_INSERT,   32'sd0,            1'b1, '{32'sd0,            ST_DONE,  8'd4}},
    '{MODE_INSERT,   32'sh7FFF_FFFF,    1'b1, '{32'sd0,            ST_DONE,  8'd5}},
    '{MODE_ALT_PEEK, 32'shAAAA_AAAA,    1'b1, '{32'sh7FFF_FFFF,    ST_DONE,  8'd5}},
    '{MODE_REMOVE,   32'sd0,            1'b1, '{32'sh7FFF_FFFF,    ST_DONE,  8'd4}},
    '{MODE_REMOVE,   32'sd0,            1'b1, '{32'sh7FFF_FFFF,    ST_DONE,  8'd3}},
    '{MODE_REMOVE,   32'sd0,            1'b1, '{32'sd0,            ST_DONE,  8'd2}},
    '{MODE_REMOVE,   32'sd0,            1'b1, '{-32'sd1,           ST_DONE,  8'd1}},
    '{MODE_INSERT,   32'sd5,            1'b0, '0},
    '{MODE_INSERT,   32'sd5,            1'b0, '0},
    '{MODE_INSERT,   32'sd3,            1'b0, '0},
    '{MODE_INSERT,   32'sd5,            1'b0, '0},
    '{MODE_REMOVE,   32'sd0,            1'b0, '0},
    '{MODE_REMOVE,   32'sd0,            1'b0, '0},
    '{MODE_PEEK,     32'sd0,            1'b0, '0},
    '{MODE_REMOVE,   32'sd0,            1'b0, '0},
    '{MODE_REMOVE,   32'sd0,            1'b0, '0},
    '{MODE_REMOVE,   32'sd0,            1'b1, '{32'sh8000_0000,    ST_DONE,  8'd0}},
    '{MODE_REMOVE,   32'sd0,            1'b1, '{32'sd0,            ST_EMPTY, 8'd0}}
  };

  max_priority_queue_heap #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_value(result_value),
    .status      (status),
    .entry_total (entry_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one item to the predicted heap and return the beat it should produce.
  function automatic res_t heap_apply(logic [MODE_W-1:0] op, logic signed [DATA_W-1:0] arg);
    res_t                     r;
    int unsigned              slot;
    int unsigned              kid;
    logic signed [DATA_W-1:0] last;
    r = '0;
    r.status = ST_DONE;
    if (op == MODE_INSERT) begin
      if (heap_cnt >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        heap_cnt++;
        slot = heap_cnt;
        while (slot != 1 && arg > heap_mem[slot / 2]) begin
          heap_mem[slot] = heap_mem[slot / 2];
          slot = slot / 2;
        end
        heap_mem[slot] = arg;
      end
    end else if (heap_cnt == 0) begin
      r.status = ST_EMPTY;
    end else if (op == MODE_REMOVE) begin
      r.result_value = heap_mem[1];
      last = heap_mem[heap_cnt];
      heap_cnt--;
      slot = 1;
      kid = 2;
      // Sift down toward the larger child; the left child wins ties.
      while (kid <= heap_cnt) begin
        if (kid < heap_cnt && heap_mem[kid + 1] > heap_mem[kid]) kid++;
        if (!(heap_mem[kid] > last)) break;
        heap_mem[slot] = heap_mem[kid];
        slot = kid;
        kid = kid * 2;
      end
      heap_mem[slot] = last;
    end else begin
      r.result_value = heap_mem[1];
    end
    r.entry_total = 8'(heap_cnt);
    return r;
  endfunction

  // Present one beat, wait for its accept, then queue what it should return.
  task automatic send_beat(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] arg,
                           input logic typed, input res_t typed_res);
    int unsigned gap;
    res_t        r;
    gap = in_gaps_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    value    <= arg;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    r = heap_apply(op, arg);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  function automatic void check_beat(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      err_cnt++;
      $display("%0t: beat with nothing expected: value %0d status %0d total %0d",
               $time, got.result_value, got.status, got.entry_total);
      return;
    end
    want = pending_results.pop_front();
    if (got.result_value !== want.result_value) begin
      err_cnt++;
      $display("%0t: result_value expected %0d got %0d", $time, want.result_value,
               got.result_value);
    end
    if (got.status !== want.status) begin
      err_cnt++;
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
    end
    if (got.entry_total !== want.entry_total) begin
      err_cnt++;
      $display("%0t: entry_total expected %0d got %0d", $time, want.entry_total,
               got.entry_total);
    end
  endfunction

  // Receiver: stall for a drawn number of cycles, then take one beat.
  initial begin
    int unsigned stall_n;
    res_t        got;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall_n = out_stalls_on ? $urandom_range(0, 13) : 0;
      if (stall_n != 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (out_valid !== 1'b1);
      got = {result_value, status, entry_total};
      @(posedge clk);
      check_beat(got);
    end
  end

  // End the run when no expected beat moves on either channel for too long.
  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) ||
        (out_valid && !out_stall && pending_results.size() != 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned              sent;
    int unsigned              phase_idx;
    int unsigned              len;
    int unsigned              ins_pct;
    int unsigned              rem_pct;
    int unsigned              pick;
    logic [1:0]               idle_style;
    phase_t                   kind;
    logic [MODE_W-1:0]        op;
    logic signed [DATA_W-1:0] arg;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      send_beat(dir_tab[k].op, dir_tab[k].arg, dir_tab[k].typed, dir_tab[k].want);
    end

    // Open with a full fill and a full drain, then mix phases at random.
    sent = 0;
    phase_idx = 0;
    while (sent < RAND_ITEMS) begin
      if (phase_idx == 0) kind = PH_FILL;
      else if (phase_idx == 1) kind = PH_DRAIN;
      else kind = phase_t'($urandom_range(0, 2));
      len = (phase_idx < 2) ? 220 : $urandom_range(40, 160);
      if (len > RAND_ITEMS - sent) len = RAND_ITEMS - sent;
      case (kind)
        PH_FILL: begin
          ins_pct = 85;
          rem_pct = 10;
        end
        PH_DRAIN: begin
          ins_pct = 10;
          rem_pct = 80;
        end
        default: begin
          ins_pct = 45;
          rem_pct = 40;
        end
      endcase
      idle_style = (phase_idx < 2) ? 2'b11 : 2'($urandom_range(0, 3));
      in_gaps_on    = idle_style[0];
      out_stalls_on = idle_style[1];
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) op = MODE_INSERT;
        else if (pick < ins_pct + rem_pct) op = MODE_REMOVE;
        else op = ($urandom_range(0, 3) == 0) ? MODE_ALT_PEEK : MODE_PEEK;
        pick = $urandom_range(0, 9);
        // Narrow values force ties; the rest spread over the whole range.
        if (pick < 4) begin
          arg = $signed(32'($urandom_range(0, 8))) - 32'sd4;
        end else if (pick == 4) begin
          case ($urandom_range(0, 3))
            0:       arg = 32'sh7FFF_FFFF;
            1:       arg = 32'sh8000_0000;
            2:       arg = -32'sd1;
            default: arg = 32'sd0;
          endcase
        end else begin
          arg = $urandom;
        end
        send_beat(op, arg, 1'b0, '0);
        sent++;
      end
      phase_idx++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
